// File: design/iss_pkg.sv
package iss_pkg;

    // Iteration counts of the shared-nothing pipelines
    localparam int LOG_STEPS    = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 30;

    // Widths
    localparam int LNV_W = 35;          // ln(1/r1) in Q.30
    localparam int NUM_W = LNV_W + 2;   // dividend, ln * 4

    // Stage counts (registers passed)
    localparam int LOG_LAT  = LOG_STEPS + 3;       // input reg, squarings, partial-product and rounding stages
    localparam int PATH_LAT = LOG_LAT + NUM_W;     // one quotient bit per stage
    localparam int TRIG_LAT = SQRT_STEPS + 1;      // sqrt and cordic both end here
    localparam int DIR_LAT  = TRIG_LAT + 2;        // product and rounding
    localparam int PIPE_LAT = PATH_LAT + 2;        // move product and output register

    localparam logic [27:0]        LN2_Q28   = 28'd186065280;
    localparam logic signed [33:0] CORDIC_K  = 34'sh026DD3B6A;
    localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;

    // Quadrant codes from the top azimuth bits
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] w;
    } dir_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int unsigned i);
        logic [29:0] a;
        begin
            case (i)
                0:       a = 30'h20000000;
                1:       a = 30'h12E4051E;
                2:       a = 30'h09FB385B;
                3:       a = 30'h051111D4;
                4:       a = 30'h028B0D43;
                5:       a = 30'h0145D7E1;
                6:       a = 30'h00A2F61E;
                7:       a = 30'h00517C55;
                8:       a = 30'h0028BE53;
                9:       a = 30'h00145F2F;
                10:      a = 30'h000A2F98;
                11:      a = 30'h000517CC;
                12:      a = 30'h00028BE6;
                13:      a = 30'h000145F3;
                14:      a = 30'h0000A2FA;
                15:      a = 30'h0000517D;
                16:      a = 30'h000028BE;
                17:      a = 30'h0000145F;
                18:      a = 30'h00000A30;
                19:      a = 30'h00000518;
                20:      a = 30'h0000028C;
                21:      a = 30'h00000146;
                22:      a = 30'h000000A3;
                23:      a = 30'h00000051;
                24:      a = 30'h00000029;
                25:      a = 30'h00000014;
                26:      a = 30'h0000000A;
                27:      a = 30'h00000005;
                28:      a = 30'h00000003;
                29:      a = 30'h00000001;
                default: a = 30'h00000000;
            endcase
            return a;
        end
    endfunction

endpackage

// File: design/iss_log.sv
// ln(1/r1) in Q.30: normalize, 30 squaring stages, then scale by ln 2
module iss_log (
    input  logic                       clk,
    input  logic                       en,
    input  logic [31:0]                rand_path,
    output logic [iss_pkg::LNV_W-1:0]  lnv
);
    import iss_pkg::*;

    logic [31:0]          r_clamp;
    logic [4:0]           msb;
    logic [31:0]          f_init;
    logic [31:0]          f_reg    [0:LOG_STEPS];
    logic [4:0]           msb_reg  [0:LOG_STEPS];
    logic [LOG_STEPS-1:0] frac_reg [0:LOG_STEPS];
    logic [35:0]          l2;
    logic [45:0]          pp_lo_reg;
    logic [45:0]          pp_hi_reg;
    logic [63:0]          ln_sum;
    logic [LNV_W-1:0]     lnv_reg;

    // zero fraction taken as the smallest one; leading-one search and normalize
    always_comb
    begin
        r_clamp = (rand_path == 32'd0) ? 32'd1 : rand_path;
        msb     = 5'd0;
        for (int b = 1; b < 32; b++)
        begin
            if (r_clamp[b])
            begin
                msb = 5'(b);
            end
        end
        f_init = r_clamp << (5'd31 - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[0]    <= f_init;
            msb_reg[0]  <= msb;
            frac_reg[0] <= '0;
        end
    end

    // one mantissa bit per squaring stage
    for (genvar k = 1; k <= LOG_STEPS; k++)
    begin : g_sq
        logic [63:0]          sq;
        logic [32:0]          sh;
        logic [31:0]          f_next;
        logic [LOG_STEPS-1:0] frac_next;

        always_comb
        begin
            sq        = {32'd0, f_reg[k-1]} * {32'd0, f_reg[k-1]};
            sh        = sq[63:31];
            frac_next = frac_reg[k-1];
            if (sh[32])
            begin
                f_next                 = sh[32:1];
                frac_next[LOG_STEPS-k] = 1'b1;
            end
            else
            begin
                f_next = sh[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[k]    <= f_next;
                msb_reg[k]  <= msb_reg[k-1];
                frac_reg[k] <= frac_next;
            end
        end
    end

    // -log2 = exponent - mantissa log; times ln2 split in two partial products
    assign l2 = {6'd32 - {1'b0, msb_reg[LOG_STEPS]}, 30'd0}
              - {6'd0, frac_reg[LOG_STEPS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg <= 46'(l2[17:0]) * 46'(LN2_Q28);
            pp_hi_reg <= 46'(l2[35:18]) * 46'(LN2_Q28);
        end
    end

    // combine and round to Q.30
    assign ln_sum = 64'(pp_lo_reg) + (64'(pp_hi_reg) << 18) + (64'd1 << 27);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lnv_reg <= ln_sum[LNV_W+27:28];
        end
    end

    assign lnv = lnv_reg;

endmodule

// File: design/iss_div.sv
// Restoring divider, one quotient bit per stage, MSB first
module iss_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [iss_pkg::NUM_W-1:0]  num,
    input  logic [31:0]                den,
    output logic [iss_pkg::NUM_W-1:0]  quot
);
    import iss_pkg::*;

    logic [31:0]      rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0] q_reg   [0:NUM_W-1];
    logic [NUM_W-1:0] num_reg [0:NUM_W-1];
    logic [31:0]      den_reg [0:NUM_W-1];

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_bit
        logic [31:0]      rem_in;
        logic [NUM_W-1:0] q_in;
        logic [NUM_W-1:0] num_in;
        logic [31:0]      den_in;
        logic [32:0]      trial;
        logic [32:0]      diff;
        logic             ge;
        logic [31:0]      rem_next;
        logic [NUM_W-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign num_in = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        // a zero divisor gives all ones, which the caller clips
        always_comb
        begin
            trial    = {rem_in, num_in[NUM_W-1-j]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[31:0] : trial[31:0];
            q_next   = {q_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                num_reg[j] <= num_in;
                den_reg[j] <= den_in;
            end
        end
    end

    assign quot = q_reg[NUM_W-1];

endmodule

// File: design/iss_sqrt.sv
// t = floor(sqrt(1 - u^2)) in Q1.30, u from the polar fraction
module iss_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] rand_polar,
    output logic [30:0] t
);
    import iss_pkg::*;

    logic signed [31:0] u;
    logic signed [63:0] usq;
    logic [63:0]        n_full;
    logic [60:0]        rem_reg [0:SQRT_STEPS];
    logic [61:0]        res_reg [0:SQRT_STEPS];

    // radicand 2^60 - u^2
    always_comb
    begin
        u      = $signed({1'b0, rand_polar[31:1]}) - ONE_Q30;
        usq    = u * u;
        n_full = (64'd1 << 60) - 64'(usq);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_full[60:0];
            res_reg[0] <= '0;
        end
    end

    // digit-by-digit root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_root
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0] trial;
        logic        ge;
        logic [60:0] rem_next;
        logic [61:0] res_next;

        always_comb
        begin
            trial = res_reg[k] + BIT;
            ge    = ({1'b0, rem_reg[k]} >= trial);
            if (ge)
            begin
                rem_next = 61'({1'b0, rem_reg[k]} - trial);
                res_next = (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
            end
        end
    end

    assign t = res_reg[SQRT_STEPS][30:0];

endmodule

// File: design/iss_cordic.sv
// cos and sin of the azimuth: quadrant from the top bits, rotation CORDIC on the rest
module iss_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        rand_azimuth,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import iss_pkg::*;

    logic signed [33:0] x_reg    [0:CORDIC_STEPS];
    logic signed [33:0] y_reg    [0:CORDIC_STEPS];
    logic signed [31:0] z_reg    [0:CORDIC_STEPS];
    logic [1:0]         quad_reg [0:CORDIC_STEPS];
    logic signed [31:0] xc;
    logic signed [31:0] yc;
    logic signed [31:0] c_next;
    logic signed [31:0] s_next;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'(ONE_Q30))
                r = ONE_Q30;
            else if (v < -34'(ONE_Q30))
                r = -ONE_Q30;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_K;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({2'b00, rand_azimuth[29:0]});
            quad_reg[0] <= rand_azimuth[31:30];
        end
    end

    // one micro-rotation per stage, floor shifts
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [31:0] ang;
        logic signed [33:0] x_next;
        logic signed [33:0] y_next;
        logic signed [31:0] z_next;

        always_comb
        begin
            dx  = y_reg[i] >>> i;
            dy  = x_reg[i] >>> i;
            ang = $signed({2'b00, atan_turn(i)});
            if (!z_reg[i][31])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - ang;
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    // clamp to unit range and fold into the quadrant
    always_comb
    begin
        xc = clamp_q30(x_reg[CORDIC_STEPS]);
        yc = clamp_q30(y_reg[CORDIC_STEPS]);
        case (quad_reg[CORDIC_STEPS])
            QUAD_I:
            begin
                c_next = xc;
                s_next = yc;
            end
            QUAD_II:
            begin
                c_next = -yc;
                s_next = xc;
            end
            QUAD_III:
            begin
                c_next = -xc;
                s_next = -yc;
            end
            QUAD_IV:
            begin
                c_next = yc;
                s_next = -xc;
            end
            default:
            begin
                c_next = xc;
                s_next = yc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign cos_q30 = c_reg;
    assign sin_q30 = s_reg;

endmodule

// File: design/isotropic_scatter_step.sv
// One flight step per transaction: samples the free path -ln(r1)/sigma and an
// isotropic direction, then moves the particle. The block is a 72-stage
// pipeline that takes one transaction per clock; its depth is set by
// the 33-stage log unit followed by the 37-stage divider (one quotient bit per
// stage) and two stages for the move. Direction (31-stage root, 30-step CORDIC)
// runs alongside. When out_ready is low with a result waiting, every stage
// holds and in_ready drops in the same cycle.
module isotropic_scatter_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [31:0]        cross_section,
    input  logic [31:0]        rand_path,
    input  logic [31:0]        rand_polar,
    input  logic [31:0]        rand_azimuth,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    output logic signed [31:0] dir_u,
    output logic signed [31:0] dir_v,
    output logic signed [31:0] dir_w,
    output logic [31:0]        path_length,
    output logic               saturated
);
    import iss_pkg::*;

    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;

    logic [LNV_W-1:0]    lnv;
    logic [31:0]         sigma_dly [0:LOG_LAT-1];
    logic [NUM_W-1:0]    quot;

    logic [30:0]         t;
    logic signed [31:0]  cos_q30;
    logic signed [31:0]  sin_q30;
    logic signed [63:0]  pv_reg;
    logic signed [63:0]  pw_reg;
    logic signed [63:0]  pv_rnd;
    logic signed [63:0]  pw_rnd;
    logic signed [31:0]  v_reg;
    logic signed [31:0]  w_reg;
    logic signed [31:0]  u_in;
    logic signed [31:0]  u_dly     [0:DIR_LAT-1];
    dir_t                dir_dly   [0:PATH_LAT-DIR_LAT-1];
    pos_t                pos_dly   [0:PATH_LAT];

    logic [31:0]         path_next;
    logic                psat_next;
    logic [31:0]         path_reg;
    logic                psat_reg;
    dir_t                dir_m_reg;
    logic signed [64:0]  prod_reg  [0:2];

    logic signed [31:0]  pos_m     [0:2];
    logic signed [31:0]  npos_next [0:2];
    logic [2:0]          clip;

    logic signed [31:0]  new_x_reg;
    logic signed [31:0]  new_y_reg;
    logic signed [31:0]  new_z_reg;
    dir_t                dir_o_reg;
    logic [31:0]         path_o_reg;
    logic                sat_o_reg;

    // global advance: the whole pipe holds while a result waits and out_ready is low
    assign en       = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // free path: log, then divide
    iss_log u_log (
        .clk       (clk),
        .en        (en),
        .rand_path (rand_path),
        .lnv       (lnv)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sigma_dly[0] <= cross_section;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                sigma_dly[i] <= sigma_dly[i-1];
            end
        end
    end

    iss_div u_div (
        .clk  (clk),
        .en   (en),
        .num  ({lnv, 2'b00}),
        .den  (sigma_dly[LOG_LAT-1]),
        .quot (quot)
    );

    // direction
    iss_sqrt u_sqrt (
        .clk        (clk),
        .en         (en),
        .rand_polar (rand_polar),
        .t          (t)
    );

    iss_cordic u_cordic (
        .clk          (clk),
        .en           (en),
        .rand_azimuth (rand_azimuth),
        .cos_q30      (cos_q30),
        .sin_q30      (sin_q30)
    );

    assign u_in   = $signed({1'b0, rand_polar[31:1]}) - ONE_Q30;
    assign pv_rnd = pv_reg + 64'sh2000_0000;
    assign pw_rnd = pw_reg + 64'sh2000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pv_reg <= $signed({1'b0, t}) * cos_q30;
            pw_reg <= $signed({1'b0, t}) * sin_q30;
            v_reg  <= 32'(pv_rnd >>> 30);
            w_reg  <= 32'(pw_rnd >>> 30);
        end
    end

    // align direction and position with the path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dly[0] <= u_in;
            for (int i = 1; i < DIR_LAT; i++)
            begin
                u_dly[i] <= u_dly[i-1];
            end
            dir_dly[0] <= '{u: u_dly[DIR_LAT-1], v: v_reg, w: w_reg};
            for (int i = 1; i < PATH_LAT - DIR_LAT; i++)
            begin
                dir_dly[i] <= dir_dly[i-1];
            end
            pos_dly[0] <= '{x: pos_x, y: pos_y, z: pos_z};
            for (int i = 1; i <= PATH_LAT; i++)
            begin
                pos_dly[i] <= pos_dly[i-1];
            end
        end
    end

    // clip the quotient, then path times direction
    assign psat_next = (quot[NUM_W-1:32] != '0);
    assign path_next = psat_next ? 32'hFFFF_FFFF : quot[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            path_reg    <= path_next;
            psat_reg    <= psat_next;
            dir_m_reg   <= dir_dly[PATH_LAT-DIR_LAT-1];
            prod_reg[0] <= $signed({1'b0, path_next}) * dir_dly[PATH_LAT-DIR_LAT-1].u;
            prod_reg[1] <= $signed({1'b0, path_next}) * dir_dly[PATH_LAT-DIR_LAT-1].v;
            prod_reg[2] <= $signed({1'b0, path_next}) * dir_dly[PATH_LAT-DIR_LAT-1].w;
        end
    end

    // round the step, move and saturate
    assign pos_m[0] = pos_dly[PATH_LAT].x;
    assign pos_m[1] = pos_dly[PATH_LAT].y;
    assign pos_m[2] = pos_dly[PATH_LAT].z;

    for (genvar k = 0; k < 3; k++)
    begin : g_move
        logic signed [64:0] rnd;
        logic signed [34:0] step;
        logic signed [35:0] sum;

        always_comb
        begin
            rnd  = prod_reg[k] + 65'sh2000_0000;
            step = 35'(rnd >>> 30);
            sum  = 36'(pos_m[k]) + 36'(step);
            if (sum > 36'sh0_7FFF_FFFF)
            begin
                npos_next[k] = 32'sh7FFF_FFFF;
                clip[k]      = 1'b1;
            end
            else if (sum < -36'sh0_8000_0000)
            begin
                npos_next[k] = 32'sh8000_0000;
                clip[k]      = 1'b1;
            end
            else
            begin
                npos_next[k] = sum[31:0];
                clip[k]      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_x_reg  <= npos_next[0];
            new_y_reg  <= npos_next[1];
            new_z_reg  <= npos_next[2];
            dir_o_reg  <= dir_m_reg;
            path_o_reg <= path_reg;
            sat_o_reg  <= psat_reg || (clip != 3'b000);
        end
    end

    assign out_valid   = vld_reg[PIPE_LAT-1];
    assign new_x       = new_x_reg;
    assign new_y       = new_y_reg;
    assign new_z       = new_z_reg;
    assign dir_u       = dir_o_reg.u;
    assign dir_v       = dir_o_reg.v;
    assign dir_w       = dir_o_reg.w;
    assign path_length = path_o_reg;
    assign saturated   = sat_o_reg;

    // checks
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dir_v <= ONE_Q30 && dir_v >= -ONE_Q30
                    && dir_w <= ONE_Q30 && dir_w >= -ONE_Q30))
        else $error("direction cosine outside unit range");

    a_pole: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dir_u == -ONE_Q30) |-> (dir_v == 32'sd0 && dir_w == 32'sd0))
        else $error("direction components misaligned at the pole");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe refused a transaction with an empty output");

endmodule
